FILE: src/ssym_pkg.sv
package ssym_pkg;

   // fixed field widths of the request and response items
   localparam int MODE_W      = 3;
   localparam int NAME_IN_W   = 16;
   localparam int TYPE_W      = 16;
   localparam int CLASS_W     = 3;
   localparam int ELEM_W      = 16;
   localparam int HANDLE_W    = 8;
   localparam int DEPTH_OUT_W = 4;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_DECLARE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd4;

   // search engine status toward the sequencer
   typedef struct packed {
      logic done;
      logic hit;
   } search_status_type;

endpackage

FILE: src/ssym_ram.sv
module ssym_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ssym_search.sv
module ssym_search import ssym_pkg::*; #(
   parameter int MAX_SYMBOLS = 256,
   parameter int MAX_DEPTH   = 16,
   parameter int NAME_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [NAME_BITS-1:0]             name,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0] sym_count,
   input  logic [$clog2(MAX_DEPTH)-1:0]     cur_depth,
   output logic [$clog2(MAX_SYMBOLS)-1:0]   sym_rd_addr,
   input  logic [NAME_BITS-1:0]             sym_rd_name,
   input  logic [$clog2(MAX_DEPTH)-1:0]     sym_rd_depth,
   output logic [$clog2(MAX_DEPTH)-1:0]     scope_rd_addr,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0] scope_rd_start,
   output search_status_type                status,
   output logic [$clog2(MAX_SYMBOLS)-1:0]   hit_idx,
   output logic [$clog2(MAX_DEPTH)-1:0]     hit_depth
);

   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int IDX_W = $clog2(MAX_SYMBOLS);
   localparam int DEP_W = $clog2(MAX_DEPTH);

   logic             active_ff, active_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic             s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   logic [DEP_W-1:0] s2_depth_ff, s2_depth_in;
   logic             s2_zero_ff, s2_zero_in;
   logic             issue;
   logic             visible;
   logic             finish;

   // walk the store newest to oldest, one read issued per cycle
   assign issue       = active_ff && (remain_ff != '0);
   assign sym_rd_addr = IDX_W'(remain_ff - CNT_W'(1));

   // stage two looks up the start of the open scope at the entry's depth
   assign scope_rd_addr = sym_rd_depth;

   // stage three: entry must lie at or above that scope's start
   assign visible = s2_valid_ff && (s2_zero_ff || (CNT_W'(s2_idx_ff) >= scope_rd_start));
   assign finish  = active_ff && (visible || (remain_ff == '0 && !s1_valid_ff));

   always_comb begin
      active_in   = active_ff;
      remain_in   = remain_ff;
      s1_valid_in = issue;
      s1_idx_in   = sym_rd_addr;
      s2_valid_in = s1_valid_ff && (sym_rd_name == name) && (sym_rd_depth <= cur_depth);
      s2_idx_in   = s1_idx_ff;
      s2_depth_in = sym_rd_depth;
      s2_zero_in  = (sym_rd_depth == '0);
      if (issue) begin
         remain_in = remain_ff - CNT_W'(1);
      end
      if (finish) begin
         active_in   = 1'b0;
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
      end
      if (go) begin
         active_in   = 1'b1;
         remain_in   = sym_count;
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      remain_ff   <= remain_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      s2_depth_ff <= s2_depth_in;
      s2_zero_ff  <= s2_zero_in;
   end

   assign status.done = finish;
   assign status.hit  = visible;
   assign hit_idx     = s2_idx_ff;
   assign hit_depth   = s2_depth_ff;

endmodule

FILE: src/scoped_symbol_table.sv
// push, pop and unused modes: result strobed in the cycle after accept, busy stays low
// declare, lookup, check: the symbol store is read one entry per cycle through
//   a three-stage read and visibility pipeline, newest entry first
// one item in flight at a time; results cannot be stalled by the receiver
// synchronous reset empties the table and returns to file scope at once
module scoped_symbol_table import ssym_pkg::*; #(
   parameter int MAX_SYMBOLS = 256,
   parameter int MAX_DEPTH   = 16,
   parameter int NAME_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [NAME_IN_W-1:0]   req_sym_name,
   input  logic [TYPE_W-1:0]      req_type_handle,
   input  logic [CLASS_W-1:0]     req_storage_class,
   input  logic [ELEM_W-1:0]      req_element_count,
   input  logic                   req_is_indirect,
   input  logic                   req_is_assumed,
   output logic                   rsp_valid,
   output logic [HANDLE_W-1:0]    rsp_symbol_handle,
   output logic                   rsp_found,
   output logic                   rsp_already_declared,
   output logic                   rsp_in_current_scope,
   output logic                   rsp_overflow,
   output logic [DEPTH_OUT_W-1:0] rsp_scope_depth
);

   localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int IDX_W   = $clog2(MAX_SYMBOLS);
   localparam int DEP_W   = $clog2(MAX_DEPTH);
   localparam int ENTRY_W = NAME_BITS + DEP_W + TYPE_W + CLASS_W + ELEM_W + 2;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [DEP_W-1:0]       depth_ff, depth_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [NAME_BITS-1:0]   name_ff, name_in;
   logic [TYPE_W-1:0]      type_ff, type_in;
   logic [CLASS_W-1:0]     class_ff, class_in;
   logic [ELEM_W-1:0]      elem_ff, elem_in;
   logic                   indirect_ff, indirect_in;
   logic                   assumed_ff, assumed_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_already_ff, rsp_already_in;
   logic                   rsp_here_ff, rsp_here_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic                   go;
   logic                   sym_we;
   logic [ENTRY_W-1:0]     sym_wr_data;
   logic [IDX_W-1:0]       sym_rd_addr;
   logic [ENTRY_W-1:0]     sym_rd_data;
   logic                   scope_we;
   logic [DEP_W-1:0]       scope_rd_addr;
   logic [CNT_W-1:0]       scope_rd_data;
   search_status_type      status;
   logic [IDX_W-1:0]       hit_idx;
   logic [DEP_W-1:0]       hit_depth;
   logic                   hit_here;

   // symbol store: name, depth, type, class, count, flags
   assign sym_wr_data = {name_ff, depth_ff, type_ff, class_ff, elem_ff,
                         indirect_ff, assumed_ff};

   ssym_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (sym_wr_data),
      .rd_addr (sym_rd_addr),
      .rd_data (sym_rd_data)
   );

   // scope start table, written on push at the new depth
   ssym_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_DEPTH)
   ) u_scope_ram (
      .clock   (clock),
      .wr_en   (scope_we),
      .wr_addr (depth_ff + DEP_W'(1)),
      .wr_data (count_ff),
      .rd_addr (scope_rd_addr),
      .rd_data (scope_rd_data)
   );

   ssym_search #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .MAX_DEPTH   (MAX_DEPTH),
      .NAME_BITS   (NAME_BITS)
   ) u_search (
      .clock          (clock),
      .reset          (reset),
      .go             (go),
      .name           (name_ff),
      .sym_count      (count_ff),
      .cur_depth      (depth_ff),
      .sym_rd_addr    (sym_rd_addr),
      .sym_rd_name    (sym_rd_data[ENTRY_W-1 -: NAME_BITS]),
      .sym_rd_depth   (sym_rd_data[ENTRY_W-NAME_BITS-1 -: DEP_W]),
      .scope_rd_addr  (scope_rd_addr),
      .scope_rd_start (scope_rd_data),
      .status         (status),
      .hit_idx        (hit_idx),
      .hit_depth      (hit_depth)
   );

   assign hit_here = status.hit && (hit_depth == depth_ff);

   // sequencer: take an item, run the search, build the result
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      depth_in       = depth_ff;
      mode_in        = mode_ff;
      name_in        = name_ff;
      type_in        = type_ff;
      class_in       = class_ff;
      elem_in        = elem_ff;
      indirect_in    = indirect_ff;
      assumed_in     = assumed_ff;
      rsp_valid_in   = 1'b0;
      rsp_handle_in  = '0;
      rsp_found_in   = 1'b0;
      rsp_already_in = 1'b0;
      rsp_here_in    = 1'b0;
      rsp_ovf_in     = 1'b0;
      rsp_depth_in   = DEPTH_OUT_W'(depth_ff);
      go             = 1'b0;
      sym_we         = 1'b0;
      scope_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in     = req_mode;
               name_in     = NAME_BITS'(req_sym_name);
               type_in     = req_type_handle;
               class_in    = req_storage_class;
               elem_in     = req_element_count;
               indirect_in = req_is_indirect;
               assumed_in  = req_is_assumed;
               case (req_mode) inside
                  MODE_DECLARE, MODE_LOOKUP, MODE_CHECK: begin
                     // the search takes the name from its register once it is loaded
                     go       = 1'b1;
                     state_in = ST_SEARCH;
                  end
                  MODE_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff == DEP_W'(MAX_DEPTH - 1)) begin
                        rsp_ovf_in = 1'b1;
                     end else begin
                        scope_we     = 1'b1;
                        depth_in     = depth_ff + DEP_W'(1);
                        rsp_depth_in = DEPTH_OUT_W'(depth_in);
                     end
                  end
                  MODE_POP: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff != '0) begin
                        depth_in     = depth_ff - DEP_W'(1);
                        rsp_depth_in = DEPTH_OUT_W'(depth_in);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_DECLARE) begin
                  if (hit_here) begin
                     rsp_handle_in  = HANDLE_W'(hit_idx);
                     rsp_found_in   = 1'b1;
                     rsp_already_in = 1'b1;
                     rsp_here_in    = 1'b1;
                  end else if (count_ff == CNT_W'(MAX_SYMBOLS)) begin
                     rsp_ovf_in = 1'b1;
                  end else begin
                     // append a new entry at the current depth
                     sym_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_handle_in = HANDLE_W'(count_ff);
                     rsp_found_in  = 1'b1;
                     rsp_here_in   = 1'b1;
                  end
               end else if (status.hit) begin
                  rsp_handle_in = HANDLE_W'(hit_idx);
                  rsp_found_in  = 1'b1;
                  rsp_here_in   = hit_here;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      name_ff        <= name_in;
      type_ff        <= type_in;
      class_ff       <= class_in;
      elem_ff        <= elem_in;
      indirect_ff    <= indirect_in;
      assumed_ff     <= assumed_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_already_ff <= rsp_already_in;
      rsp_here_ff    <= rsp_here_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_depth_ff   <= rsp_depth_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_symbol_handle    = rsp_handle_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_already_declared = rsp_already_ff;
   assign rsp_in_current_scope = rsp_here_ff;
   assign rsp_overflow         = rsp_ovf_ff;
   assign rsp_scope_depth      = rsp_depth_ff;

endmodule

FILE: src/ssym_checker.sv
module ssym_checker import ssym_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [MODE_W-1:0]      req_mode,
   input logic                   rsp_valid,
   input logic [HANDLE_W-1:0]    rsp_symbol_handle,
   input logic                   rsp_found,
   input logic                   rsp_already_declared,
   input logic                   rsp_in_current_scope,
   input logic                   rsp_overflow
);

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // scope operations answer in the next cycle without going busy
   a_scope_op_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_PUSH || req_mode == MODE_POP))
      |=> (rsp_valid && !busy))
      else $error("scope item did not complete in one cycle");

   // a search item holds the block busy while the store is walked
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_DECLARE || req_mode == MODE_LOOKUP ||
                          req_mode == MODE_CHECK))
      |=> (busy && !rsp_valid))
      else $error("search item did not hold busy");

   // no symbol means handle zero, and a miss never claims the current scope
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found)
      |-> (rsp_symbol_handle == '0 && !rsp_in_current_scope && !rsp_already_declared))
      else $error("miss result carries symbol data");

   // an existing declaration is always a hit in the current scope, never overflow
   a_already_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_already_declared)
      |-> (rsp_found && rsp_in_current_scope && !rsp_overflow))
      else $error("already-declared result inconsistent");

endmodule

bind scoped_symbol_table ssym_checker u_ssym_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_mode             (req_mode),
   .rsp_valid            (rsp_valid),
   .rsp_symbol_handle    (rsp_symbol_handle),
   .rsp_found            (rsp_found),
   .rsp_already_declared (rsp_already_declared),
   .rsp_in_current_scope (rsp_in_current_scope),
   .rsp_overflow         (rsp_overflow)
);

FILE: test/scoped_symbol_table_test.sv
`timescale 1ns / 1ps
module scoped_symbol_table_test;
   import ssym_pkg::*;

   localparam int TABLE_SIZE   = 256;
   localparam int DEPTH_LIMIT  = 16;
   localparam int POOL_SIZE    = 12;
   localparam int QUIET_TAIL   = 120;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_STEPS = 260;
   localparam int FILL_NAMES   = 300;

   localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_SPARE_LAST  = 3'd7;
   localparam logic [CLASS_W-1:0]   CLASS_GLOBAL     = 3'd6;
   localparam logic [NAME_IN_W-1:0] FILL_BASE        = 16'h8000;
   localparam logic [NAME_IN_W-1:0] SPILL_BASE       = 16'hC000;

   // how the stored fields of a queued item are chosen
   localparam int FIELDS_RANDOM = 0;
   localparam int FIELDS_ZERO   = 1;
   localparam int FIELDS_ONES   = 2;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [NAME_IN_W-1:0] sym_name;
      logic [TYPE_W-1:0]    type_handle;
      logic [CLASS_W-1:0]   storage_class;
      logic [ELEM_W-1:0]    element_count;
      logic                 is_indirect;
      logic                 is_assumed;
   } table_op_type;

   typedef struct {
      logic [HANDLE_W-1:0]    handle;
      logic                   found;
      logic                   already;
      logic                   here;
      logic                   overflow;
      logic [DEPTH_OUT_W-1:0] depth;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0]      req_mode          = '0;
   logic [NAME_IN_W-1:0]   req_sym_name      = '0;
   logic [TYPE_W-1:0]      req_type_handle   = '0;
   logic [CLASS_W-1:0]     req_storage_class = '0;
   logic [ELEM_W-1:0]      req_element_count = '0;
   logic                   req_is_indirect   = 1'b0;
   logic                   req_is_assumed    = 1'b0;
   logic                   rsp_valid;
   logic [HANDLE_W-1:0]    rsp_symbol_handle;
   logic                   rsp_found;
   logic                   rsp_already_declared;
   logic                   rsp_in_current_scope;
   logic                   rsp_overflow;
   logic [DEPTH_OUT_W-1:0] rsp_scope_depth;

   scoped_symbol_table uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_sym_name         (req_sym_name),
      .req_type_handle      (req_type_handle),
      .req_storage_class    (req_storage_class),
      .req_element_count    (req_element_count),
      .req_is_indirect      (req_is_indirect),
      .req_is_assumed       (req_is_assumed),
      .rsp_valid            (rsp_valid),
      .rsp_symbol_handle    (rsp_symbol_handle),
      .rsp_found            (rsp_found),
      .rsp_already_declared (rsp_already_declared),
      .rsp_in_current_scope (rsp_in_current_scope),
      .rsp_overflow         (rsp_overflow),
      .rsp_scope_depth      (rsp_scope_depth)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   table_op_type  pending_ops[$];
   table_rsp_type expected_rsps[$];
   int items_driven    = 0;
   int items_accepted  = 0;
   int total_items     = 0;
   int gap_left        = 0;
   int quiet_cycles    = 0;
   int error_count     = 0;
   int results_checked = 0;
   int fresh_declares  = 0;
   int redeclares      = 0;
   int overflow_count  = 0;
   int lookup_hits     = 0;
   int deepest_scope   = 0;

   // shadow symbol table: only name and depth decide any result
   logic [NAME_IN_W-1:0] entry_name [TABLE_SIZE];
   int entry_depth [TABLE_SIZE];
   int scope_base [DEPTH_LIMIT];
   int entry_total = 0;
   int open_depth  = 0;

   initial begin
      foreach (scope_base[d]) scope_base[d] = 0;
   end

   // newest entry with this name that is still inside an open scope
   function automatic bit find_newest_visible(input logic [NAME_IN_W-1:0] name,
                                              output int at);
      at = 0;
      for (int i = entry_total - 1; i >= 0; i--) begin
         if (entry_name[i] == name && entry_depth[i] <= open_depth &&
             i >= scope_base[entry_depth[i]]) begin
            at = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic table_rsp_type apply_table_op(input table_op_type op);
      table_rsp_type r;
      int at;
      r = '{default: '0};
      case (op.mode)
         MODE_DECLARE: begin
            if (find_newest_visible(op.sym_name, at) && entry_depth[at] == open_depth) begin
               r.handle  = HANDLE_W'(at);
               r.found   = 1'b1;
               r.already = 1'b1;
               r.here    = 1'b1;
               redeclares++;
            end else if (entry_total >= TABLE_SIZE) begin
               r.overflow = 1'b1;
               overflow_count++;
            end else begin
               entry_name[entry_total]  = op.sym_name;
               entry_depth[entry_total] = open_depth;
               r.handle = HANDLE_W'(entry_total);
               r.found  = 1'b1;
               r.here   = 1'b1;
               entry_total++;
               fresh_declares++;
            end
         end
         MODE_LOOKUP, MODE_CHECK: begin
            if (find_newest_visible(op.sym_name, at)) begin
               r.handle = HANDLE_W'(at);
               r.found  = 1'b1;
               r.here   = (entry_depth[at] == open_depth);
               lookup_hits++;
            end
         end
         MODE_PUSH: begin
            if (open_depth + 1 >= DEPTH_LIMIT) begin
               r.overflow = 1'b1;
               overflow_count++;
            end else begin
               open_depth++;
               scope_base[open_depth] = entry_total;
               if (open_depth > deepest_scope) deepest_scope = open_depth;
            end
         end
         MODE_POP: begin
            if (open_depth > 0) open_depth--;
         end
         default: ;
      endcase
      r.depth = DEPTH_OUT_W'(open_depth);
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // stimulus generation, with its own view of the scope depth
   int gen_depth = 0;
   logic [NAME_IN_W-1:0] name_pool [POOL_SIZE];

   task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [NAME_IN_W-1:0] name,
                           input int fill_kind = FIELDS_RANDOM);
      table_op_type op;
      op.mode     = mode;
      op.sym_name = name;
      if (fill_kind == FIELDS_ZERO) begin
         op.type_handle   = '0;
         op.storage_class = '0;
         op.element_count = '0;
         op.is_indirect   = 1'b0;
         op.is_assumed    = 1'b0;
      end else if (fill_kind == FIELDS_ONES) begin
         op.type_handle   = '1;
         op.storage_class = CLASS_GLOBAL;
         op.element_count = '1;
         op.is_indirect   = 1'b1;
         op.is_assumed    = 1'b1;
      end else begin
         op.type_handle   = TYPE_W'($urandom);
         op.storage_class = CLASS_W'($urandom_range(0, CLASS_GLOBAL));
         op.element_count = ELEM_W'($urandom);
         op.is_indirect   = 1'($urandom);
         op.is_assumed    = 1'($urandom);
      end
      pending_ops.insert(pending_ops.size(), op);
      if (mode == MODE_PUSH && gen_depth < DEPTH_LIMIT - 1) gen_depth++;
      else if (mode == MODE_POP && gen_depth > 0) gen_depth--;
   endtask

   function automatic logic [NAME_IN_W-1:0] pick_name();
      if ($urandom_range(0, 99) < 85) return name_pool[$urandom_range(0, POOL_SIZE - 1)];
      return NAME_IN_W'($urandom);
   endfunction

   // nest down to the depth limit, then one push past it, then lookups
   task automatic climb_to_limit();
      while (gen_depth < DEPTH_LIMIT - 1) begin
         queue_op(MODE_PUSH, pick_name());
         if ($urandom_range(0, 2) == 0) queue_op(MODE_DECLARE, pick_name());
      end
      queue_op(MODE_PUSH, pick_name());
      repeat ($urandom_range(2, 6)) queue_op(MODE_LOOKUP, pick_name());
   endtask

   // a small well-formed scope: open, shadow some names, look them up, close, look up again
   task automatic scoped_block();
      int n;
      n = $urandom_range(1, 4);
      queue_op(MODE_PUSH, pick_name());
      repeat (n) queue_op(MODE_DECLARE, pick_name());
      repeat (n + 1) queue_op($urandom_range(0, 1) ? MODE_LOOKUP : MODE_CHECK, pick_name());
      queue_op(MODE_POP, pick_name());
      repeat (n) queue_op(MODE_LOOKUP, pick_name());
   endtask

   initial begin : stimulus
      int sel;
      foreach (name_pool[p]) name_pool[p] = NAME_IN_W'($urandom_range(0, 16'h7FFF));

      // directed: empty table, pop at file scope, field extremes, shadowing, closed sibling scopes, spare modes
      queue_op(MODE_LOOKUP, '0);
      queue_op(MODE_POP, '0);
      queue_op(MODE_DECLARE, '0, FIELDS_ZERO);
      queue_op(MODE_DECLARE, '1, FIELDS_ONES);
      queue_op(MODE_DECLARE, '0);
      queue_op(MODE_CHECK, '1);
      queue_op(MODE_PUSH, '0);
      queue_op(MODE_LOOKUP, '0);
      queue_op(MODE_CHECK, '0);
      queue_op(MODE_DECLARE, '0);
      queue_op(MODE_LOOKUP, '0);
      queue_op(MODE_POP, '0);
      queue_op(MODE_LOOKUP, '0);
      queue_op(MODE_PUSH, '1);
      queue_op(MODE_LOOKUP, '0);
      queue_op(MODE_CHECK, '1);
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         queue_op(MODE_W'(m), NAME_IN_W'($urandom));
      queue_op(MODE_POP, '0);
      queue_op(MODE_CHECK, '0);

      // random walk over scopes with a small name pool
      climb_to_limit();
      for (int k = 0; k < RANDOM_STEPS; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25) queue_op(MODE_DECLARE, pick_name());
         else if (sel < 50) queue_op(MODE_LOOKUP, pick_name());
         else if (sel < 60) queue_op(MODE_CHECK, pick_name());
         else if (sel < 73) queue_op(MODE_PUSH, pick_name());
         else if (sel < 87) queue_op(MODE_POP, pick_name());
         else if (sel < 91)
            queue_op(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), pick_name());
         else if (sel < 92) climb_to_limit();
         else scoped_block();
      end

      // fill the table with distinct names, depth fixed for the last stretch
      for (int i = 0; i < FILL_NAMES; i++) begin
         if (i < FILL_NAMES / 2 && $urandom_range(0, 7) == 0)
            queue_op($urandom_range(0, 1) ? MODE_PUSH : MODE_POP, pick_name());
         if ($urandom_range(0, 9) == 0) queue_op(MODE_LOOKUP, pick_name());
         queue_op(MODE_DECLARE, FILL_BASE | NAME_IN_W'(i));
      end

      // full table: redeclares still succeed, new names overflow
      repeat (60) begin
         sel = $urandom_range(0, 99);
         if (sel < 40)
            queue_op(MODE_DECLARE, FILL_BASE | NAME_IN_W'($urandom_range(200, FILL_NAMES - 1)));
         else if (sel < 55)
            queue_op(MODE_DECLARE, SPILL_BASE | NAME_IN_W'($urandom_range(0, 16'h0FFF)));
         else if (sel < 68)
            queue_op(MODE_LOOKUP, FILL_BASE | NAME_IN_W'($urandom_range(0, FILL_NAMES - 1)));
         else if (sel < 80) queue_op(MODE_CHECK, pick_name());
         else if (sel < 90) queue_op(MODE_PUSH, pick_name());
         else queue_op(MODE_POP, pick_name());
      end
      total_items = pending_ops.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d new symbols, %0d redeclares, %0d overflows",
               items_accepted, results_checked, fresh_declares, redeclares, overflow_count);
      $display("deepest scope %0d, table holds %0d entries, %0d lookups and checks found a symbol",
               deepest_scope, entry_total, lookup_hits);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // driver: one item on the ports until taken, random idle bursts between items while many remain
   always @(negedge clock) begin : driver
      table_op_type next_op;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || items_accepted == items_driven) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            next_op = pending_ops.pop_front();
            req_mode          <= next_op.mode;
            req_sym_name      <= next_op.sym_name;
            req_type_handle   <= next_op.type_handle;
            req_storage_class <= next_op.storage_class;
            req_element_count <= next_op.element_count;
            req_is_indirect   <= next_op.is_indirect;
            req_is_assumed    <= next_op.is_assumed;
            start <= 1'b1;
            items_driven++;
            if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 9);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check strobed results, predict each accepted item, watch for stalls
   always @(posedge clock) begin : monitor
      table_op_type  seen_op;
      table_rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, expected none, actual handle %0h",
                        $time, rsp_symbol_handle);
            end else begin
               want = expected_rsps.pop_front();
               results_checked++;
               compare_field("symbol_handle", 16'(want.handle), 16'(rsp_symbol_handle));
               compare_field("found", 16'(want.found), 16'(rsp_found));
               compare_field("already_declared", 16'(want.already), 16'(rsp_already_declared));
               compare_field("in_current_scope", 16'(want.here), 16'(rsp_in_current_scope));
               compare_field("overflow", 16'(want.overflow), 16'(rsp_overflow));
               compare_field("scope_depth", 16'(want.depth), 16'(rsp_scope_depth));
            end
         end

         if (start && !busy) begin
            seen_op.mode          = req_mode;
            seen_op.sym_name      = req_sym_name;
            seen_op.type_handle   = req_type_handle;
            seen_op.storage_class = req_storage_class;
            seen_op.element_count = req_element_count;
            seen_op.is_indirect   = req_is_indirect;
            seen_op.is_assumed    = req_is_assumed;
            expected_rsps.insert(expected_rsps.size(), apply_table_op(seen_op));
            items_accepted++;
         end

         if ((start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item or result for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule

FILE: scoped_symbol_table.f
src/ssym_pkg.sv
src/ssym_ram.sv
src/ssym_search.sv
src/scoped_symbol_table.sv
src/ssym_checker.sv
test/scoped_symbol_table_test.sv
